// ----- rtl/core/rcsa_pkg.sv -----
// Package for the rotate/crop/scale pixel address core.
// Holds shared widths, the setup state type, the geometry bundle and a clamp helper.
// No dependencies.
`default_nettype none
package rcsa_pkg;

   localparam int MaxDim    = 2048;
   localparam int DimW      = 12;   // width of a dimension register
   localparam int CoordW    = 11;   // width of a pixel coordinate
   localparam int OffsetW   = 22;   // width of the linear offset
   localparam int ProdW     = 23;   // coordinate times crop size
   localparam int QuotW     = 11;   // bits of a scaled coordinate
   localparam int DivStages = QuotW;
   localparam int SetupNumW = 23;   // crop numerator in the setup divider
   localparam int CntW      = 5;
   localparam int Latency   = DivStages + 5;

   // register indexes on the control port
   localparam logic [2:0] RegSrcWidth  = 3'd0;
   localparam logic [2:0] RegSrcHeight = 3'd1;
   localparam logic [2:0] RegDstWidth  = 3'd2;
   localparam logic [2:0] RegDstHeight = 3'd3;
   localparam logic [2:0] RegRotation  = 3'd4;

   // rotation codes
   localparam logic [1:0] RotNone = 2'd0;
   localparam logic [1:0] Rot90   = 2'd1;
   localparam logic [1:0] Rot180  = 2'd2;
   localparam logic [1:0] Rot270  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_FIN,
      ST_OFS
   } setup_state_type;

   // frame geometry worked out once per configuration
   typedef struct packed {
      logic [DimW-1:0] sw;
      logic [DimW-1:0] sh;
      logic [DimW-1:0] dw;
      logic [DimW-1:0] dh;
      logic [1:0]      rot;
      logic [DimW-1:0] cw;
      logic [DimW-1:0] ch;
      logic [DimW-1:0] offx;
      logic [DimW-1:0] offy;
   } geom_type;

   // zero reads as one, anything above the maximum reads as the maximum
   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      r = v;
      if (v == '0) r = DimW'(1);
      else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/rotate_crop_scale_pixel_address_core.sv -----
// Top level of the rotate/crop/scale pixel address core.
// Instantiates rcsa_setup and two rcsa_divpipe units; uses rcsa_pkg.
//
//   channel  ports                                   handshake
//   request  req_out_x, req_out_y                    start, busy
//   result   rsp_src_x, rsp_src_y, rsp_src_offset,   rsp_strobe (one cycle)
//            rsp_out_of_range
//   control  csr_index, csr_data                     csr_valid, csr_ready
//
// One pixel per clock while busy is low; each result passes through the
// 11-stage divider pipeline plus five arithmetic stages.
// After reset and after every control write busy is high while the crop
// is worked out by the serial divider in the setup unit.
// The result side cannot stall, so the pipeline never holds.
`default_nettype none
module rotate_crop_scale_pixel_address_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rcsa_pkg::CoordW-1:0]   req_out_x,
   input  wire logic [rcsa_pkg::CoordW-1:0]   req_out_y,
   output logic                               rsp_strobe,
   output logic      [rcsa_pkg::CoordW-1:0]   rsp_src_x,
   output logic      [rcsa_pkg::CoordW-1:0]   rsp_src_y,
   output logic      [rcsa_pkg::OffsetW-1:0]  rsp_src_offset,
   output logic                               rsp_out_of_range,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [rcsa_pkg::DimW-1:0]     csr_data
);
   import rcsa_pkg::*;

   geom_type geom;
   logic     take;

   logic                 v0_ff, v1_ff, v3_ff, v4_ff, vo_ff;
   logic [DivStages-1:0] vd_ff;
   logic [DivStages-1:0] oor_d_ff;
   logic                 oor0_ff, oor1_ff, oor3_ff, oor4_ff;
   logic [CoordW-1:0]    x0_ff, y0_ff;
   logic [ProdW-1:0]     px1_ff, py1_ff;
   logic [QuotW-1:0]     qx, qy;
   logic [DimW-1:0]      ux3_ff, uy3_ff;
   logic [DimW-1:0]      sx4_ff, sy4_ff;
   logic [CoordW-1:0]    sx_o_ff, sy_o_ff;
   logic [OffsetW-1:0]   off_o_ff;
   logic                 oor_o_ff;
   logic [2*DimW-1:0]    lin;

   rcsa_setup u_setup (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .busy, .geom
   );

   assign take = start && !busy;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; vd_ff <= '0;
         v3_ff <= 1'b0; v4_ff <= 1'b0; vo_ff <= 1'b0;
      end else begin
         v0_ff <= take;
         v1_ff <= v0_ff;
         vd_ff <= {vd_ff[DivStages-2:0], v1_ff};
         v3_ff <= vd_ff[DivStages-1];
         v4_ff <= v3_ff;
         vo_ff <= v4_ff;
      end
   end

   // capture and range check
   always_ff @(posedge clock) begin
      x0_ff   <= req_out_x;
      y0_ff   <= req_out_y;
      oor0_ff <= (DimW'(req_out_x) >= geom.dw) || (DimW'(req_out_y) >= geom.dh);
   end

   // coordinate times crop size
   always_ff @(posedge clock) begin
      px1_ff  <= x0_ff * geom.cw;
      py1_ff  <= y0_ff * geom.ch;
      oor1_ff <= oor0_ff;
   end

   rcsa_divpipe u_divx (.clock, .num(px1_ff), .den(geom.dw), .quot(qx));
   rcsa_divpipe u_divy (.clock, .num(py1_ff), .den(geom.dh), .quot(qy));

   always_ff @(posedge clock) begin
      oor_d_ff <= {oor_d_ff[DivStages-2:0], oor1_ff};
   end

   // add crop offset: upright coordinate
   always_ff @(posedge clock) begin
      ux3_ff  <= geom.offx + DimW'(qx);
      uy3_ff  <= geom.offy + DimW'(qy);
      oor3_ff <= oor_d_ff[DivStages-1];
   end

   // map back into sensor space
   always_ff @(posedge clock) begin
      oor4_ff <= oor3_ff;
      case (geom.rot)
         RotNone: begin sx4_ff <= ux3_ff; sy4_ff <= uy3_ff; end
         Rot90: begin
            sx4_ff <= uy3_ff;
            sy4_ff <= geom.sh - DimW'(1) - ux3_ff;
         end
         Rot180: begin
            sx4_ff <= geom.sw - DimW'(1) - ux3_ff;
            sy4_ff <= geom.sh - DimW'(1) - uy3_ff;
         end
         default: begin
            sx4_ff <= geom.sw - DimW'(1) - uy3_ff;
            sy4_ff <= ux3_ff;
         end
      endcase
   end

   // linear offset and output register
   assign lin = sy4_ff * geom.sw + (2*DimW)'(sx4_ff);

   always_ff @(posedge clock) begin
      oor_o_ff <= oor4_ff;
      if (oor4_ff) begin
         sx_o_ff  <= '0;
         sy_o_ff  <= '0;
         off_o_ff <= '0;
      end else begin
         sx_o_ff  <= sx4_ff[CoordW-1:0];
         sy_o_ff  <= sy4_ff[CoordW-1:0];
         off_o_ff <= lin[OffsetW-1:0];
      end
   end

   assign rsp_strobe       = vo_ff;
   assign rsp_src_x        = sx_o_ff;
   assign rsp_src_y        = sy_o_ff;
   assign rsp_src_offset   = off_o_ff;
   assign rsp_out_of_range = oor_o_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##Latency rsp_strobe)
      else $error("result missing after fixed latency");
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range) |->
         (rsp_src_x == '0 && rsp_src_y == '0 && rsp_src_offset == '0))
      else $error("out-of-range result carries an address");
   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("control write did not start setup");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/rcsa_setup.sv -----
// Control registers and the setup sequencer of the address core.
// Works out crop size and offsets with a bit-serial divider. Uses rcsa_pkg.
`default_nettype none
module rcsa_setup (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [rcsa_pkg::DimW-1:0] csr_data,
   output logic                    busy,
   output rcsa_pkg::geom_type      geom
);
   import rcsa_pkg::*;

   logic [DimW-1:0] src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [1:0]      rot_ff;
   logic            wr;

   setup_state_type state_ff, state_in;

   geom_type            geom_ff;
   logic [DimW-1:0]     uw_ff, uh_ff;
   logic [2*DimW-1:0]   p1_ff, p2_ff;
   logic                wide_ff;
   logic [SetupNumW-1:0] num_ff, quot_ff;
   logic [DimW-1:0]     den_ff;
   logic [DimW:0]       rem_ff;
   logic [CntW-1:0]     cnt_ff;
   logic [DimW:0]       rem_try;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid;
   assign busy      = (state_ff != ST_IDLE);
   assign geom      = geom_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DimW'(480);
         src_h_ff <= DimW'(320);
         dst_w_ff <= DimW'(160);
         dst_h_ff <= DimW'(240);
         rot_ff   <= Rot180;
      end else if (wr) begin
         case (csr_index)
            RegSrcWidth:  src_w_ff <= csr_data;
            RegSrcHeight: src_h_ff <= csr_data;
            RegDstWidth:  dst_w_ff <= csr_data;
            RegDstHeight: dst_h_ff <= csr_data;
            RegRotation:  rot_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // state register; reset runs the setup once
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_PREP;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: state_in = ST_IDLE;
         ST_PREP: state_in = ST_MUL;
         ST_MUL:  state_in = ST_CMP;
         ST_CMP:  state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == CntW'(SetupNumW - 1)) state_in = ST_FIN;
         ST_FIN:  state_in = ST_OFS;
         ST_OFS:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // any write restarts the setup
      if (wr) state_in = ST_PREP;
   end

   assign rem_try = {rem_ff[DimW-1:0], num_ff[SetupNumW-1]};

   // setup datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_PREP: begin
            geom_ff.sw  <= clamp_dim(src_w_ff);
            geom_ff.sh  <= clamp_dim(src_h_ff);
            geom_ff.dw  <= clamp_dim(dst_w_ff);
            geom_ff.dh  <= clamp_dim(dst_h_ff);
            geom_ff.rot <= rot_ff;
            if (rot_ff[0]) begin
               uw_ff <= clamp_dim(src_h_ff);
               uh_ff <= clamp_dim(src_w_ff);
            end else begin
               uw_ff <= clamp_dim(src_w_ff);
               uh_ff <= clamp_dim(src_h_ff);
            end
         end
         ST_MUL: begin
            p1_ff <= uw_ff * geom_ff.dh;
            p2_ff <= uh_ff * geom_ff.dw;
         end
         ST_CMP: begin
            wide_ff <= (p1_ff > p2_ff);
            num_ff  <= (p1_ff > p2_ff) ? p2_ff[SetupNumW-1:0] : p1_ff[SetupNumW-1:0];
            den_ff  <= (p1_ff > p2_ff) ? geom_ff.dh : geom_ff.dw;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            quot_ff <= '0;
         end
         ST_DIV: begin
            // one quotient bit per cycle
            num_ff <= {num_ff[SetupNumW-2:0], 1'b0};
            cnt_ff <= cnt_ff + CntW'(1);
            if (rem_try >= {1'b0, den_ff}) begin
               rem_ff  <= rem_try - {1'b0, den_ff};
               quot_ff <= {quot_ff[SetupNumW-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_try;
               quot_ff <= {quot_ff[SetupNumW-2:0], 1'b0};
            end
         end
         ST_FIN: begin
            geom_ff.cw <= wide_ff ? quot_ff[DimW-1:0] : uw_ff;
            geom_ff.ch <= wide_ff ? uh_ff : quot_ff[DimW-1:0];
         end
         ST_OFS: begin
            geom_ff.offx <= (uw_ff - geom_ff.cw) >> 1;
            geom_ff.offy <= (uh_ff - geom_ff.ch) >> 1;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/core/rcsa_divpipe.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Scales a coordinate product down by the destination size. Uses rcsa_pkg.
`default_nettype none
module rcsa_divpipe (
   input  wire logic                         clock,
   input  wire logic [rcsa_pkg::ProdW-1:0]   num,
   input  wire logic [rcsa_pkg::DimW-1:0]    den,
   output logic      [rcsa_pkg::QuotW-1:0]   quot
);
   import rcsa_pkg::*;

   logic [ProdW-1:0] rem_ff  [DivStages];
   logic [QuotW-1:0] quot_ff [DivStages];
   logic [ProdW-1:0] rem_src [DivStages];
   logic [QuotW-1:0] q_src   [DivStages];

   always_comb begin
      for (int i = 0; i < DivStages; i++) begin
         rem_src[i] = (i == 0) ? num : rem_ff[(i == 0) ? 0 : i-1];
         q_src[i]   = (i == 0) ? '0  : quot_ff[(i == 0) ? 0 : i-1];
      end
   end

   // stage i settles quotient bit QuotW-1-i
   always_ff @(posedge clock) begin
      for (int i = 0; i < DivStages; i++) begin
         if (rem_src[i] >= (ProdW'(den) << (QuotW-1-i))) begin
            rem_ff[i]  <= rem_src[i] - (ProdW'(den) << (QuotW-1-i));
            quot_ff[i] <= q_src[i] | (QuotW'(1) << (QuotW-1-i));
         end else begin
            rem_ff[i]  <= rem_src[i];
            quot_ff[i] <= q_src[i];
         end
      end
   end

   assign quot = quot_ff[DivStages-1];

endmodule
`default_nettype wire
